FILE: rtl/pcpf_pkg.sv
// Shared types and constants for the PWM capture to PPM frame unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pcpf_pkg;

  // Default parameter values.
  localparam int DEF_NUM_CHANNELS       = 8;
  localparam int DEF_CHANNELS_PER_TIMER = 4;

  // Field widths fixed by the interface.
  localparam int ACTION_W  = 2;
  localparam int CHANNEL_W = 3;
  localparam int CAPTURE_W = 16;
  localparam int PERIOD_W  = 17;
  localparam int GAP_W     = 24;
  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 2;

  // Input action codes.
  localparam logic [ACTION_W-1:0] ACT_OVERFLOW = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CAPTURE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SEGMENT  = 2'd2;

  // Result kinds.
  localparam logic KIND_WIDTH   = 1'b0;
  localparam logic KIND_SEGMENT = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TICKS  = 2'd3;

  // Register reset values.
  localparam logic [PERIOD_W-1:0] RST_TIMER_PERIOD = 17'd36000;
  localparam logic [WORD_W-1:0]   RST_WIDTH_LIMIT  = 32'd72000;
  localparam logic [GAP_W-1:0]    RST_GAP_TICKS    = 24'd36000;
  localparam logic [WORD_W-1:0]   RST_FRAME_TICKS  = 32'd1440000;

  typedef struct packed {
    logic [PERIOD_W-1:0] timer_period;
    logic [WORD_W-1:0]   width_limit;
    logic [GAP_W-1:0]    gap_ticks;
    logic [WORD_W-1:0]   frame_ticks;
  } cfg_t;

  // One-cycle strobes, each qualified by the item actually being processed.
  typedef struct packed {
    logic ovf;
    logic cap;
    logic ppm;
  } ev_t;

endpackage

`default_nettype wire

FILE: rtl/pcpf_capture.sv
// Capture bookkeeping: overflow counters, rising-edge snapshots and stored widths.
// Computes the clamped pulse width on a falling edge. Depends on pcpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcpf_capture #(
  parameter int NUM_CHANNELS       = pcpf_pkg::DEF_NUM_CHANNELS,
  parameter int CHANNELS_PER_TIMER = pcpf_pkg::DEF_CHANNELS_PER_TIMER,
  parameter int SLOT_W             = $clog2(NUM_CHANNELS + 1)
) (
  input  wire                               clk,
  input  wire                               rst,
  input  pcpf_pkg::ev_t                     ev,
  input  pcpf_pkg::cfg_t                    cfg,
  input  wire                               timer_group,
  input  wire [pcpf_pkg::CHANNEL_W-1:0]     channel,
  input  wire                               pin_high,
  input  wire [pcpf_pkg::CAPTURE_W-1:0]     capture_value,
  input  wire [SLOT_W-1:0]                  slot,
  output logic [pcpf_pkg::WORD_W-1:0]       width,
  output logic [pcpf_pkg::WORD_W-1:0]       slot_width
);
  import pcpf_pkg::*;

  localparam int CH_IDX_W = $clog2(NUM_CHANNELS);

  logic [WORD_W-1:0]    ovf_count  [2];
  logic [CAPTURE_W-1:0] rise_cap   [NUM_CHANNELS];
  logic [WORD_W-1:0]    rise_ovf   [NUM_CHANNELS];
  logic [WORD_W-1:0]    chan_width [NUM_CHANNELS];

  logic [CH_IDX_W-1:0]           ch_idx;
  logic [CH_IDX_W-1:0]           slot_idx;
  logic                          grp;
  logic [WORD_W-1:0]             ovf_diff;
  logic [WORD_W-1:0]             prod;
  logic [WORD_W-1:0]             span;

  assign ch_idx   = CH_IDX_W'(channel);
  assign slot_idx = CH_IDX_W'(slot);
  // Groups beyond the second share the second overflow counter.
  assign grp      = (32'(channel) >= CHANNELS_PER_TIMER);

  assign ovf_diff = ovf_count[grp] - rise_ovf[ch_idx];
  assign prod     = ovf_diff * WORD_W'(cfg.timer_period);
  assign span     = prod + WORD_W'(capture_value) - WORD_W'(rise_cap[ch_idx]);
  assign width    = (span > cfg.width_limit) ? cfg.width_limit : span;

  assign slot_width = chan_width[slot_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      ovf_count[0] <= '0;
      ovf_count[1] <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        rise_cap[i]   <= '0;
        rise_ovf[i]   <= '0;
        chan_width[i] <= '0;
      end
    end else begin
      if (ev.ovf) begin
        ovf_count[timer_group] <= ovf_count[timer_group] + WORD_W'(1);
      end
      if (ev.cap) begin
        if (pin_high) begin
          rise_cap[ch_idx] <= capture_value;
          rise_ovf[ch_idx] <= ovf_count[grp];
        end else begin
          chan_width[ch_idx] <= width;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pcpf_ppm.sv
// PPM frame sequencer: alternates low gaps and channel high times, then a filler.
// Reads stored widths from pcpf_capture through the slot index. Depends on pcpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcpf_ppm #(
  parameter int NUM_CHANNELS = pcpf_pkg::DEF_NUM_CHANNELS,
  parameter int SLOT_W       = $clog2(NUM_CHANNELS + 1)
) (
  input  wire                          clk,
  input  wire                          rst,
  input  pcpf_pkg::ev_t                ev,
  input  pcpf_pkg::cfg_t               cfg,
  input  wire [pcpf_pkg::WORD_W-1:0]   slot_width,
  output logic [SLOT_W-1:0]            slot,
  output logic                         level,
  output logic [pcpf_pkg::WORD_W-1:0]  ticks
);
  import pcpf_pkg::*;

  logic              phase_high;
  logic              phase_high_next;
  logic [SLOT_W-1:0] slot_next;
  logic [WORD_W-1:0] frame_total;
  logic [WORD_W-1:0] frame_total_next;
  logic [WORD_W-1:0] gap_w;
  logic [WORD_W-1:0] chan_ticks;

  assign gap_w = WORD_W'(cfg.gap_ticks);
  // A channel never goes shorter than the gap.
  assign chan_ticks = (slot_width < gap_w) ? gap_w : ((slot_width << 1) - gap_w);

  always_comb begin
    phase_high_next  = phase_high;
    slot_next        = slot;
    frame_total_next = frame_total;
    level            = phase_high;
    ticks            = gap_w;
    if (!phase_high) begin
      frame_total_next = frame_total + gap_w;
      phase_high_next  = 1'b1;
    end else begin
      phase_high_next = 1'b0;
      if (32'(slot) < NUM_CHANNELS) begin
        ticks            = chan_ticks;
        frame_total_next = frame_total + chan_ticks;
        slot_next        = slot + SLOT_W'(1);
      end else begin
        ticks            = cfg.frame_ticks - frame_total;
        frame_total_next = '0;
        slot_next        = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_high  <= 1'b0;
      slot        <= '0;
      frame_total <= '0;
    end else if (ev.ppm) begin
      phase_high  <= phase_high_next;
      slot        <= slot_next;
      frame_total <= frame_total_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pwm_capture_to_ppm_frame_unit.sv
// Measures servo PWM high times on capture events and emits PPM frame segments.
// One input item is taken per clock when the result side keeps up: an item is
// registered, then processed by a single 32x17 multiply with add and clamp
// (capture) or one add and compare (PPM), and its result, if any, lands in the
// output register. Sustained rate is one item per cycle while the result side
// keeps up. Depends on pcpf_pkg, pcpf_capture and pcpf_ppm.
`timescale 1ns / 1ps
`default_nettype none

module pwm_capture_to_ppm_frame_unit #(
  parameter int NUM_CHANNELS       = pcpf_pkg::DEF_NUM_CHANNELS,
  parameter int CHANNELS_PER_TIMER = pcpf_pkg::DEF_CHANNELS_PER_TIMER
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [pcpf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [pcpf_pkg::WORD_W-1:0]         cfg_data,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire [pcpf_pkg::ACTION_W-1:0]       action,
  input  wire                                timer_group,
  input  wire [pcpf_pkg::CHANNEL_W-1:0]      channel,
  input  wire                                pin_high,
  input  wire [pcpf_pkg::CAPTURE_W-1:0]      capture_value,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic                               result_kind,
  output logic [pcpf_pkg::CHANNEL_W-1:0]     out_channel,
  output logic [pcpf_pkg::WORD_W-1:0]        measured_width,
  output logic                               out_level,
  output logic [pcpf_pkg::WORD_W-1:0]        segment_ticks
);
  import pcpf_pkg::*;

  localparam int SLOT_W = $clog2(NUM_CHANNELS + 1);

  cfg_t cfg;

  // Item register.
  logic                 item_valid;
  logic [ACTION_W-1:0]  item_action;
  logic                 item_group;
  logic [CHANNEL_W-1:0] item_channel;
  logic                 item_pin_high;
  logic [CAPTURE_W-1:0] item_capture;

  logic        is_cap;
  logic        is_seg;
  logic        has_result;
  logic        out_free;
  logic        fire;
  ev_t         ev;

  logic [WORD_W-1:0] width;
  logic [WORD_W-1:0] slot_width;
  logic [SLOT_W-1:0] slot;
  logic              seg_level;
  logic [WORD_W-1:0] seg_ticks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timer_period <= RST_TIMER_PERIOD;
      cfg.width_limit  <= RST_WIDTH_LIMIT;
      cfg.gap_ticks    <= RST_GAP_TICKS;
      cfg.frame_ticks  <= RST_FRAME_TICKS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TIMER_PERIOD: cfg.timer_period <= cfg_data[PERIOD_W-1:0];
        REG_WIDTH_LIMIT:  cfg.width_limit  <= cfg_data;
        REG_GAP_TICKS:    cfg.gap_ticks    <= cfg_data[GAP_W-1:0];
        REG_FRAME_TICKS:  cfg.frame_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Edges on channels beyond the configured count are dropped.
  assign is_cap     = (item_action == ACT_CAPTURE) && (32'(item_channel) < NUM_CHANNELS);
  assign is_seg     = (item_action == ACT_SEGMENT);
  assign has_result = (is_cap && !item_pin_high) || is_seg;
  assign out_free   = !out_valid || out_ready;
  assign fire       = item_valid && (!has_result || out_free);
  assign in_ready   = !item_valid || fire;

  assign ev.ovf = fire && (item_action == ACT_OVERFLOW);
  assign ev.cap = fire && is_cap;
  assign ev.ppm = fire && is_seg;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_action   <= action;
      item_group    <= timer_group;
      item_channel  <= channel;
      item_pin_high <= pin_high;
      item_capture  <= capture_value;
    end
  end

  pcpf_capture #(
    .NUM_CHANNELS       (NUM_CHANNELS),
    .CHANNELS_PER_TIMER (CHANNELS_PER_TIMER),
    .SLOT_W             (SLOT_W)
  ) u_capture (
    .clk           (clk),
    .rst           (rst),
    .ev            (ev),
    .cfg           (cfg),
    .timer_group   (item_group),
    .channel       (item_channel),
    .pin_high      (item_pin_high),
    .capture_value (item_capture),
    .slot          (slot),
    .width         (width),
    .slot_width    (slot_width)
  );

  pcpf_ppm #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SLOT_W       (SLOT_W)
  ) u_ppm (
    .clk        (clk),
    .rst        (rst),
    .ev         (ev),
    .cfg        (cfg),
    .slot_width (slot_width),
    .slot       (slot),
    .level      (seg_level),
    .ticks      (seg_ticks)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      if (is_seg) begin
        result_kind    <= KIND_SEGMENT;
        out_channel    <= '0;
        measured_width <= '0;
        out_level      <= seg_level;
        segment_ticks  <= seg_ticks;
      end else begin
        result_kind    <= KIND_WIDTH;
        out_channel    <= item_channel;
        measured_width <= width;
        out_level      <= 1'b0;
        segment_ticks  <= '0;
      end
    end
  end

endmodule

`default_nettype wire
